/* rtl/pcx_row_pixel_unpacker_unit_defines.svh */
// assertion macros for the pcx row pixel unpacker
`ifndef PCX_ROW_PIXEL_UNPACKER_UNIT_DEFINES_SVH
`define PCX_ROW_PIXEL_UNPACKER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PCX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PCX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pcx_pkg.sv */
// types, codes and constants of the pcx row pixel unpacker
`timescale 1ns / 1ps
package pcx_pkg;

    localparam int ROW_BYTES_DFLT      = 8192;
    localparam int LINE_BYTES_MAX_DFLT = 2048;

    localparam int MODE_W     = 4;
    localparam int BPL_W      = 12;
    localparam int BYTE_IDX_W = 13;
    localparam int PIX_IDX_W  = 14;
    localparam int PIX_VAL_W  = 24;
    localparam int STS_W      = 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic [MODE_W-1:0] MODE_MONO   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_CH2    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_PL2    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_PL3    = 4'd3;
    localparam logic [MODE_W-1:0] MODE_PL4    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_CH4    = 4'd5;
    localparam logic [MODE_W-1:0] MODE_BYTE   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_RGB    = 4'd7;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_UNSUP = 2'd1;
    localparam logic [STS_W-1:0] STS_RANGE = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BPL        = 1'b1;

    localparam logic [MODE_W-1:0] RST_COLOR_MODE = MODE_BYTE;
    localparam logic [BPL_W-1:0]  RST_BPL        = 12'd80;

    typedef struct packed {
        logic [MODE_W-1:0] color_mode;
        logic [BPL_W-1:0]  bytes_per_line;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_DATA,
        ST_FIN
    } t_state;

endpackage

/* rtl/pcx_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module pcx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pcx_ctrl.sv */
// item sequencer: row writes, per-plane fetch and pixel assembly
`timescale 1ns / 1ps
module pcx_ctrl
    import pcx_pkg::*;
#(
    parameter int ROW_BYTES      = ROW_BYTES_DFLT,
    parameter int LINE_BYTES_MAX = LINE_BYTES_MAX_DFLT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_op,
    input  logic [BYTE_IDX_W-1:0]        i_byte_index,
    input  logic [7:0]                   i_byte_value,
    input  logic [PIX_IDX_W-1:0]         i_pixel_index,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [PIX_VAL_W-1:0]         o_pixel_value,
    output logic [STS_W-1:0]             o_status,
    output logic                         o_mem_we,
    output logic [$clog2(ROW_BYTES)-1:0] o_mem_waddr,
    output logic [7:0]                   o_mem_wdata,
    output logic [$clog2(ROW_BYTES)-1:0] o_mem_raddr,
    input  logic [7:0]                   i_mem_rdata
);

    localparam int AW    = $clog2(ROW_BYTES);
    localparam int ACC_W = $clog2(ROW_BYTES + LINE_BYTES_MAX + 1);

    t_state                r_state, n_state;
    logic [ACC_W-1:0]      r_acc, n_acc;
    logic [1:0]            r_plane, n_plane;
    logic [1:0]            r_last, n_last;
    logic [2:0]            r_sub, n_sub;
    logic [PIX_VAL_W-1:0]  r_pix, n_pix;
    logic [STS_W-1:0]      r_sts, n_sts;
    logic                  r_out_valid, n_out_valid;
    logic [PIX_VAL_W-1:0]  r_out_pix, n_out_pix;
    logic [STS_W-1:0]      r_out_sts, n_out_sts;

    logic [BPL_W-1:0]      bpl;
    logic [PIX_IDX_W-1:0]  off;
    logic [STS_W-1:0]      sts;
    logic [1:0]            last;
    logic                  acc_wrap;
    logic                  out_free;
    logic [2:0]            sh;
    logic [7:0]            ch2_shift;
    logic [PIX_VAL_W-1:0]  merged;

    always_comb begin
        if (32'(i_cfg.bytes_per_line) > LINE_BYTES_MAX) begin
            bpl = BPL_W'(LINE_BYTES_MAX);
        end else begin
            bpl = i_cfg.bytes_per_line;
        end
    end

    // byte offset within a plane, status and last plane index for a read
    always_comb begin
        off  = '0;
        sts  = STS_OK;
        last = 2'd0;
        case (i_cfg.color_mode)
            MODE_MONO: off = i_pixel_index >> 3;
            MODE_CH2:  off = i_pixel_index >> 2;
            MODE_PL2, MODE_PL3, MODE_PL4: begin
                off  = i_pixel_index >> 3;
                last = 2'(i_cfg.color_mode - 4'd1);
            end
            MODE_CH4:  off = i_pixel_index >> 1;
            MODE_BYTE: off = i_pixel_index;
            MODE_RGB: begin
                off  = i_pixel_index;
                last = 2'd2;
            end
            default:   sts = STS_UNSUP;
        endcase
        if (sts == STS_OK && 32'(off) >= 32'(bpl)) begin
            sts = STS_RANGE;
        end
    end

    assign acc_wrap  = 32'(r_acc) >= ROW_BYTES;
    assign out_free  = !r_out_valid || i_ready;
    assign sh        = 3'd7 - r_sub;
    assign ch2_shift = i_mem_rdata >> {2'd3 - r_sub[1:0], 1'b0};

    always_comb begin
        case (i_cfg.color_mode)
            MODE_MONO: merged = {{(PIX_VAL_W-1){1'b0}}, ~i_mem_rdata[sh]};
            MODE_CH2:  merged = PIX_VAL_W'(ch2_shift[1:0]);
            MODE_PL2, MODE_PL3, MODE_PL4:
                merged = r_pix | (PIX_VAL_W'(i_mem_rdata[sh]) << r_plane);
            MODE_CH4:  merged = r_sub[0] ? PIX_VAL_W'(i_mem_rdata[3:0])
                                         : PIX_VAL_W'(i_mem_rdata[7:4]);
            MODE_BYTE: merged = PIX_VAL_W'(i_mem_rdata);
            MODE_RGB:  merged = {r_pix[15:0], i_mem_rdata};
            default:   merged = r_pix;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && i_op == OP_READ) begin
                    n_state = (sts == STS_OK) ? ST_ADDR : ST_FIN;
                end
            end
            ST_ADDR: begin
                if (!acc_wrap) begin
                    n_state = ST_DATA;
                end
            end
            ST_DATA: n_state = (r_plane == r_last) ? ST_FIN : ST_ADDR;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready     = (r_state == ST_IDLE);
        o_mem_we    = (r_state == ST_IDLE) && i_valid && i_op == OP_WRITE
                      && 32'(i_byte_index) < ROW_BYTES;
        o_mem_waddr = AW'(i_byte_index);
        o_mem_wdata = i_byte_value;
        o_mem_raddr = AW'(r_acc);
    end

    // datapath
    always_comb begin
        n_acc       = r_acc;
        n_plane     = r_plane;
        n_last      = r_last;
        n_sub       = r_sub;
        n_pix       = r_pix;
        n_sts       = r_sts;
        n_out_valid = r_out_valid;
        n_out_pix   = r_out_pix;
        n_out_sts   = r_out_sts;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_valid && i_op == OP_READ) begin
                    n_acc   = ACC_W'(off);
                    n_plane = 2'd0;
                    n_last  = last;
                    n_sub   = i_pixel_index[2:0];
                    n_pix   = '0;
                    n_sts   = sts;
                end
            end
            ST_ADDR: begin
                if (acc_wrap) begin
                    n_acc = r_acc - ACC_W'(ROW_BYTES);
                end
            end
            ST_DATA: begin
                n_pix = merged;
                if (r_plane != r_last) begin
                    n_acc   = r_acc + ACC_W'(bpl);
                    n_plane = r_plane + 2'd1;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = r_pix;
                    n_out_sts   = r_sts;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_acc     <= n_acc;
        r_plane   <= n_plane;
        r_last    <= n_last;
        r_sub     <= n_sub;
        r_pix     <= n_pix;
        r_sts     <= n_sts;
        r_out_pix <= n_out_pix;
        r_out_sts <= n_out_sts;
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_value = r_out_pix;
    assign o_status      = r_out_sts;

endmodule

/* rtl/pcx_row_pixel_unpacker_unit.sv */
// top level of the pcx row pixel unpacker: config registers, row ram, sequencer
//
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_ready         i_op, i_byte_index, i_byte_value,
//                                                 i_pixel_index
//  output    out        o_valid / i_ready         o_pixel_value, o_status
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// a write item is accepted in ST_IDLE; the byte goes into the row ram at acceptance
// a read item fetches n = 1, 3 or 2..4 bytes from the row ram, passing ST_ADDR and ST_DATA
// once per byte, plus one more ST_ADDR pass each time a plane address wraps past ROW_BYTES
// an item flagged unsupported or outside the row goes from ST_IDLE straight to ST_FIN
// the output register holds a result while the next item is accepted
// reset is synchronous; the row ram is not cleared
`timescale 1ns / 1ps
`include "pcx_row_pixel_unpacker_unit_defines.svh"
module pcx_row_pixel_unpacker_unit
    import pcx_pkg::*;
#(
    parameter int ROW_BYTES      = ROW_BYTES_DFLT,
    parameter int LINE_BYTES_MAX = LINE_BYTES_MAX_DFLT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [BPL_W-1:0]      i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_op,
    input  logic [BYTE_IDX_W-1:0] i_byte_index,
    input  logic [7:0]            i_byte_value,
    input  logic [PIX_IDX_W-1:0]  i_pixel_index,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIX_VAL_W-1:0]  o_pixel_value,
    output logic [STS_W-1:0]      o_status
);

    localparam int AW = $clog2(ROW_BYTES);

    t_cfg          r_cfg, n_cfg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_COLOR_MODE: n_cfg.color_mode     = i_cfg_data[MODE_W-1:0];
                REG_BPL:        n_cfg.bytes_per_line = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_mode     <= RST_COLOR_MODE;
            r_cfg.bytes_per_line <= RST_BPL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    pcx_ram #(
        .WIDTH (8),
        .DEPTH (ROW_BYTES)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    pcx_ctrl #(
        .ROW_BYTES      (ROW_BYTES),
        .LINE_BYTES_MAX (LINE_BYTES_MAX)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_byte_index  (i_byte_index),
        .i_byte_value  (i_byte_value),
        .i_pixel_index (i_pixel_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_value (o_pixel_value),
        .o_status      (o_status),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    `PCX_ASSERT_NOW(a_we_only_on_write, mem_we, i_valid && o_ready && i_op == OP_WRITE, "row ram written without a write item")
    `PCX_ASSERT_NOW(a_flagged_zero, o_valid && o_status != STS_OK, o_pixel_value == '0, "flagged result carries a nonzero pixel")
    `PCX_ASSERT_NEXT(a_narrow_pixel, o_valid && o_status == STS_OK && r_cfg.color_mode != MODE_RGB, $past(o_pixel_value[PIX_VAL_W-1:8]) == '0, "palette pixel wider than a byte")

endmodule
